[src/dnfrf_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the row filter.
`default_nettype none
package dnfrf_pkg;

  // Fixed field widths of the streaming items
  localparam int ACTION_W = 2;
  localparam int GROUP_W  = 3;
  localparam int COLUMN_W = 8;
  localparam int VALUE_W  = 16;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // Default table dimensions
  localparam int MAX_CONDITIONS_DEF = 16;
  localparam int MAX_GROUPS_DEF     = 8;

  // Input action codes
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ROW   = 2'd2;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROW   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BEYOND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic                wr;       // append the incoming condition
    logic                clr;      // empty the table
    logic                row;      // compare a row element, set hit flags
    logic                hit_clr;  // drop all hit flags
    logic                g_clr;    // restart the group sweep
    logic                g_step;   // advance the group sweep
    logic                load;     // load the result register
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic                matched;
    logic                changed;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic beyond;     // add group index past the next group
    logic full;       // table or group count exhausted for this add
    logic had;        // table holds conditions
    logic grp_empty;  // no groups open
    logic grp_hit;    // swept group fully satisfied
    logic g_last;     // swept group is the last open one
  } sts_t;

endpackage
`default_nettype wire

[src/dnf_equality_row_filter.sv]
// Top level of the DNF equality row filter: stream ports around controller and datapath.
// Add, clear and non-final row elements sustain one item per cycle while the result channel
// does not stall; add and clear results are valid in the cycle after the input transfer.
// A final row element starts the group sweep, which checks one OR-group per cycle and stops
// early at the first satisfied group; no new item is taken until the sweep ends.
// Results sit in an output register; a new item is taken in the cycle that frees it.
// Reset (rst_n low, synchronous) empties the table, drops hit flags and the result.
`default_nettype none
module dnf_equality_row_filter #(
  parameter int MAX_CONDITIONS = dnfrf_pkg::MAX_CONDITIONS_DEF,
  parameter int MAX_GROUPS     = dnfrf_pkg::MAX_GROUPS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  // input channel
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [31:0] in_tdata,   // group[2:0], column[10:3], value[26:11], zero[31:27]
  input  wire [1:0]  in_tuser,   // action[1:0]
  input  wire        in_tlast,   // last element of a row
  // result channel
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // status[1:0], matched[2], changed[3], zero[7:4]
  output logic [1:0] out_tuser   // kind[1:0]
);
  import dnfrf_pkg::*;

  // Unpack the input transfer
  logic [GROUP_W-1:0]  in_group;
  logic [COLUMN_W-1:0] in_column;
  logic [VALUE_W-1:0]  in_value;

  assign in_group  = in_tdata[GROUP_W-1:0];
  assign in_column = in_tdata[GROUP_W+COLUMN_W-1:GROUP_W];
  assign in_value  = in_tdata[GROUP_W+COLUMN_W+VALUE_W-1:GROUP_W+COLUMN_W];

  cmd_t cmd;
  sts_t sts;

  logic [KIND_W-1:0]   out_kind;
  logic [STATUS_W-1:0] out_status;
  logic                out_matched;
  logic                out_changed;

  // Controller: decodes actions, sequences the group sweep, owns result valid
  dnfrf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: condition cells compare every row element in parallel;
  // the group sweep reduces one group per cycle
  dnfrf_dp #(
    .MAX_CONDITIONS (MAX_CONDITIONS),
    .MAX_GROUPS     (MAX_GROUPS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_group    (in_group),
    .in_column   (in_column),
    .in_value    (in_value),
    .sts         (sts),
    .out_kind    (out_kind),
    .out_status  (out_status),
    .out_matched (out_matched),
    .out_changed (out_changed)
  );

  // Pack the result transfer
  assign out_tuser = out_kind;
  assign out_tdata = {4'b0000, out_changed, out_matched, out_status};

endmodule
`default_nettype wire

[src/dnfrf_dp.sv]
// Datapath: condition cells, fill count, group count, group sweep and result register.
`default_nettype none
module dnfrf_dp #(
  parameter int MAX_CONDITIONS = dnfrf_pkg::MAX_CONDITIONS_DEF,
  parameter int MAX_GROUPS     = dnfrf_pkg::MAX_GROUPS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire dnfrf_pkg::cmd_t              cmd,
  input  wire [dnfrf_pkg::GROUP_W-1:0]      in_group,
  input  wire [dnfrf_pkg::COLUMN_W-1:0]     in_column,
  input  wire [dnfrf_pkg::VALUE_W-1:0]      in_value,
  output dnfrf_pkg::sts_t                   sts,
  output logic [dnfrf_pkg::KIND_W-1:0]      out_kind,
  output logic [dnfrf_pkg::STATUS_W-1:0]    out_status,
  output logic                              out_matched,
  output logic                              out_changed
);
  import dnfrf_pkg::*;

  localparam int NW = $clog2(MAX_CONDITIONS + 1);
  localparam int GW = $clog2(MAX_GROUPS + 1);
  localparam int CW = (GW > GROUP_W + 1) ? GW : GROUP_W + 1;

  logic [NW-1:0]      count_r;
  logic [GW-1:0]      gused_r;
  logic [GROUP_W-1:0] g_r;

  logic                      valid_r [MAX_CONDITIONS];
  logic                      hit_r   [MAX_CONDITIONS];
  logic [GROUP_W-1:0]        grp_r [MAX_CONDITIONS];
  logic [COLUMN_W-1:0]       col_r [MAX_CONDITIONS];
  logic [VALUE_W-1:0]        val_r [MAX_CONDITIONS];

  logic [MAX_CONDITIONS-1:0] in_g;
  logic [MAX_CONDITIONS-1:0] miss;

  logic opens;

  logic [KIND_W-1:0]   kind_r;
  logic [STATUS_W-1:0] status_r;
  logic                matched_r;
  logic                changed_r;

  assign opens = (CW'(in_group) == CW'(gused_r));

  assign sts.beyond    = (CW'(in_group) > CW'(gused_r));
  assign sts.full      = (count_r == NW'(MAX_CONDITIONS)) ||
                         (opens && (gused_r == GW'(MAX_GROUPS)));
  assign sts.had       = (count_r != '0);
  assign sts.grp_empty = (gused_r == '0);
  assign sts.grp_hit   = (|in_g) && !(|miss);
  assign sts.g_last    = ((CW'(g_r) + CW'(1)) == CW'(gused_r));

  // Condition cells; the table fills in order, so the free slot is the fill count
  for (genvar i = 0; i < MAX_CONDITIONS; i++) begin : g_cell
    logic we;
    assign we      = cmd.wr && (count_r == NW'(i));
    assign in_g[i] = valid_r[i] && (grp_r[i] == g_r);
    assign miss[i] = in_g[i] && !hit_r[i];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
        hit_r[i]   <= 1'b0;
      end else if (cmd.clr) begin
        valid_r[i] <= 1'b0;
        hit_r[i]   <= 1'b0;
      end else if (we) begin
        valid_r[i] <= 1'b1;
        hit_r[i]   <= 1'b0;
      end else if (cmd.hit_clr) begin
        hit_r[i]   <= 1'b0;
      end else if (cmd.row && valid_r[i] && (col_r[i] == in_column) &&
                   (val_r[i] == in_value)) begin
        hit_r[i]   <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (we) begin
        grp_r[i] <= in_group;
        col_r[i] <= in_column;
        val_r[i] <= in_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      gused_r <= '0;
      g_r     <= '0;
    end else begin
      if (cmd.clr) begin
        count_r <= '0;
        gused_r <= '0;
      end else if (cmd.wr) begin
        count_r <= count_r + NW'(1);
        if (opens) gused_r <= gused_r + GW'(1);
      end
      if (cmd.g_clr) g_r <= '0;
      else if (cmd.g_step) g_r <= g_r + GROUP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= cmd.kind;
      status_r  <= cmd.status;
      matched_r <= cmd.matched;
      changed_r <= cmd.changed;
    end
  end

  assign out_kind    = kind_r;
  assign out_status  = status_r;
  assign out_matched = matched_r;
  assign out_changed = changed_r;

endmodule
`default_nettype wire

[src/dnfrf_ctrl.sv]
// Controller: handshakes, action decode and the group sweep sequence.
`default_nettype none
module dnfrf_ctrl (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [dnfrf_pkg::ACTION_W-1:0]    in_action,
  input  wire                              in_last,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  input  wire dnfrf_pkg::sts_t             sts,
  output dnfrf_pkg::cmd_t                  cmd
);
  import dnfrf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    accept    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = out_free;
        accept    = in_tvalid && out_free;
        if (accept) begin
          unique case (in_action)
            ACT_ADD: begin
              cmd.load = 1'b1;
              cmd.kind = KIND_ADD;
              if (sts.beyond) begin
                cmd.status = STAT_BEYOND;
              end else if (sts.full) begin
                cmd.status = STAT_FULL;
              end else begin
                cmd.wr      = 1'b1;
                cmd.changed = 1'b1;
              end
            end
            ACT_CLEAR: begin
              cmd.clr     = 1'b1;
              cmd.load    = 1'b1;
              cmd.kind    = KIND_CLEAR;
              cmd.changed = sts.had;
            end
            ACT_ROW: begin
              cmd.row = 1'b1;
              if (in_last) begin
                cmd.g_clr = 1'b1;
                state_nxt = S_EVAL;
              end
            end
            default: ;
          endcase
        end
      end
      S_EVAL: begin
        if (sts.grp_empty || sts.grp_hit || sts.g_last) begin
          cmd.load    = 1'b1;
          cmd.kind    = KIND_ROW;
          cmd.matched = sts.grp_empty || sts.grp_hit;
          cmd.hit_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.g_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

endmodule
`default_nettype wire
